// File: rtl/csbb_pkg.sv
// shared constants, types and helpers for the seating search block
package csbb_pkg;
	localparam int MAX_N    = 8;
	localparam int COST_MAX = 1000;
	localparam int PW       = $clog2(MAX_N);
	localparam int NW       = $clog2(MAX_N + 1);
	localparam int CW       = 10;
	localparam int TW       = 14;
	localparam int DEPTH    = MAX_N * MAX_N;
	localparam int AW       = $clog2(DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE, ST_ID1, ST_ID2, ST_ID3, ST_SCAN, ST_EV1, ST_EV2, ST_EV3,
		ST_WR1, ST_WR2, ST_WR3, ST_CHK, ST_OUT
	} state_t;

	function automatic logic [AW-1:0] pair_addr(input logic [PW-1:0] a,
		input logic [PW-1:0] b);
		pair_addr = AW'(int'(a) * MAX_N + int'(b));
	endfunction
endpackage

// File: rtl/circular_seating_branch_and_bound.sv
// top level: cost matrix load and branch-and-bound seating search
//
// Usage: load the directed cost matrix one entry per transaction: drive
// row_person, col_person, pair_cost and last_entry with start high; a
// transaction is taken at a clock edge where start is high and busy is low.
// Entries load at one per cycle while busy is low. The entry marked last_entry starts the
// search and busy rises on the next cycle.
// The search runs on one cost ram with a read port: the identity bound runs
// the ID states per seat, each search node the SCAN, EV and CHK states (plus
// the WR states at the final level, which adds the wrap-round pair) with a
// scan per backtrack; the total is data dependent. Then num_people results
// appear on consecutive cycles, each for one cycle with result_valid high,
// last_seat on the final one. The receiver cannot stall; results are
// not held. num_people is written through cfg_we/cfg_wdata while idle,
// which the block does not enforce; values below 2 act as 2, values above
// 8 act as 8. Reset puts the block idle with num_people at 8. Cost entries
// hold no reset value and must be written before a search reads them.
module circular_seating_branch_and_bound (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [2:0]              row_person,
	input  logic [2:0]              col_person,
	input  logic [9:0]              pair_cost,
	input  logic                    last_entry,
	input  logic                    cfg_we,
	input  logic [3:0]              cfg_wdata,
	output logic                    result_valid,
	output logic [2:0]              seat,
	output logic [2:0]              person,
	output logic [13:0]             total_cost,
	output logic                    last_seat
);
	import csbb_pkg::*;

	state_t state_q, state_d;

	logic [3:0]    num_q;
	logic [NW-1:0] n_q;
	logic [PW-1:0] lvl_q, idx_q, cand_q;
	logic [TW-1:0] acc_q, best_q;
	logic [PW-1:0] seats_q [MAX_N];
	logic [PW-1:0] bseats_q [MAX_N];
	logic [NW-1:0] ncand_q [MAX_N];
	logic [TW-1:0] lcost_q [MAX_N];
	logic [MAX_N-1:0] used_q;

	logic          accept;
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [CW-1:0] ram_wdata, ram_rdata;
	logic [TW-1:0] rd_ext;

	logic [PW-1:0] prv_lvl, prv_seat, id_next, pick;
	logic          found;
	logic [NW-1:0] n_clamp, scan_from;
	logic          last_lvl, id_end, out_end;

	assign accept    = start && (state_q == ST_IDLE);
	assign rd_ext    = TW'(ram_rdata);
	assign prv_lvl   = lvl_q - PW'(1);
	assign prv_seat  = seats_q[prv_lvl];
	assign last_lvl  = NW'(lvl_q) == n_q - NW'(1);
	assign id_end    = NW'(idx_q) == n_q - NW'(1);
	assign out_end   = id_end;
	assign id_next   = id_end ? PW'(0) : idx_q + PW'(1);
	assign scan_from = ncand_q[lvl_q];

	always_comb begin
		if (num_q < 4'd2) begin
			n_clamp = NW'(2);
		end else if (NW'(num_q) > NW'(MAX_N) || num_q > 4'(MAX_N)) begin
			n_clamp = NW'(MAX_N);
		end else begin
			n_clamp = NW'(num_q);
		end
	end

	// lowest free person not below the level's next candidate
	always_comb begin
		found = 1'b0;
		pick  = '0;
		for (int i = MAX_N - 1; i >= 0; i--) begin
			if (!used_q[i] && NW'(i) >= scan_from && NW'(i) < n_q) begin
				found = 1'b1;
				pick  = PW'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && last_entry) state_d = ST_ID1;
			ST_ID1:  state_d = ST_ID2;
			ST_ID2:  state_d = ST_ID3;
			ST_ID3:  state_d = id_end ? ST_SCAN : ST_ID1;
			ST_SCAN: begin
				if (found) begin
					state_d = ST_EV1;
				end else if (prv_lvl == '0) begin
					state_d = ST_OUT;
				end
			end
			ST_EV1:  state_d = ST_EV2;
			ST_EV2:  state_d = ST_EV3;
			ST_EV3:  state_d = last_lvl ? ST_WR1 : ST_CHK;
			ST_WR1:  state_d = ST_WR2;
			ST_WR2:  state_d = ST_WR3;
			ST_WR3:  state_d = ST_CHK;
			ST_CHK:  state_d = ST_SCAN;
			ST_OUT:  if (out_end) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_raddr = '0;
		case (state_q)
			ST_ID1:  ram_raddr = pair_addr(idx_q, id_next);
			ST_ID2:  ram_raddr = pair_addr(id_next, idx_q);
			ST_EV1:  ram_raddr = pair_addr(cand_q, prv_seat);
			ST_EV2:  ram_raddr = pair_addr(prv_seat, cand_q);
			ST_WR1:  ram_raddr = pair_addr(cand_q, seats_q[0]);
			ST_WR2:  ram_raddr = pair_addr(seats_q[0], cand_q);
			default: ram_raddr = '0;
		endcase
		ram_we    = accept;
		ram_waddr = pair_addr(row_person, col_person);
		ram_wdata = (pair_cost > CW'(COST_MAX)) ? CW'(COST_MAX) : pair_cost;
	end

	always_comb begin
		busy         = state_q != ST_IDLE;
		result_valid = state_q == ST_OUT;
		seat         = idx_q;
		person       = bseats_q[idx_q];
		total_cost   = best_q;
		last_seat    = (state_q == ST_OUT) && out_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			num_q   <= 4'(MAX_N);
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				num_q <= cfg_wdata;
			end
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && last_entry) begin
					n_q   <= n_clamp;
					idx_q <= '0;
					acc_q <= '0;
					for (int i = 0; i < MAX_N; i++) begin
						bseats_q[i] <= PW'(i);
					end
				end
			end
			ST_ID2:  acc_q <= acc_q + rd_ext;
			ST_ID3: begin
				acc_q <= acc_q + rd_ext;
				idx_q <= id_next;
				if (id_end) begin
					best_q     <= acc_q + rd_ext;
					lvl_q      <= PW'(1);
					used_q     <= MAX_N'(1);
					seats_q[0] <= '0;
					lcost_q[0] <= '0;
					for (int i = 0; i < MAX_N; i++) begin
						ncand_q[i] <= NW'(1);
					end
				end
			end
			ST_SCAN: begin
				if (found) begin
					cand_q          <= pick;
					seats_q[lvl_q]  <= pick;
					ncand_q[lvl_q]  <= NW'(pick) + NW'(1);
				end else begin
					lvl_q <= prv_lvl;
					idx_q <= '0;
					if (prv_lvl != '0) begin
						used_q[seats_q[prv_lvl]] <= 1'b0;
					end
				end
			end
			ST_EV2:  acc_q <= lcost_q[prv_lvl] + rd_ext;
			ST_EV3, ST_WR2, ST_WR3: acc_q <= acc_q + rd_ext;
			ST_CHK: begin
				if (acc_q < best_q) begin
					if (last_lvl) begin
						best_q <= acc_q;
						for (int i = 0; i < MAX_N; i++) begin
							bseats_q[i] <= seats_q[i];
						end
					end else begin
						used_q[cand_q]           <= 1'b1;
						lcost_q[lvl_q]           <= acc_q;
						lvl_q                    <= lvl_q + PW'(1);
						ncand_q[lvl_q + PW'(1)]  <= NW'(1);
					end
				end
			end
			ST_OUT:  idx_q <= idx_q + PW'(1);
			default: ;
		endcase
	end

	csbb_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_cost_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);
endmodule

// File: rtl/csbb_ram.sv
// generic ram with one write port and one registered read port
module csbb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/csbb_checker.sv
// port-level checks for the seating search block, bound to the top level
module csbb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        last_entry,
	input logic        result_valid,
	input logic [2:0]  seat,
	input logic        last_seat
);
	// results only while the block is busy
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("result outside busy");

	// a plain load transaction leaves the block free
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !last_entry |=> !busy) else $error("load stalled");

	// no result right after a transaction is taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !result_valid) else $error("early result");

	// seats run in order without gaps
	a_seat_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_seat |=> result_valid && seat == $past(seat) + 3'd1)
		else $error("broken seat run");

	// the run ends after the final seat
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_seat |=> !result_valid) else $error("run overrun");
endmodule

bind circular_seating_branch_and_bound csbb_checker u_csbb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.last_entry   (last_entry),
	.result_valid (result_valid),
	.seat         (seat),
	.last_seat    (last_seat)
);
